FILE: hdl/bpc_pkg.sv
// Package for the barometric compensation block: shared types, register
// indexes, status codes, fixed constants and small arithmetic helpers.
// No dependencies.
package bpc_pkg;

    localparam int QueueDepth = 2;

    localparam logic [31:0] TEMP_OFFSET = 32'd4000;
    localparam logic [31:0] PRESS_SCALE = 32'd50000;
    localparam logic [31:0] COEF_SQ     = 32'd3038;
    localparam logic [31:0] COEF_LIN    = 32'd7357;
    localparam logic [31:0] COEF_OFS    = 32'd3791;
    localparam logic [31:0] HALF_SCALE  = 32'd32768;

    typedef enum logic [2:0] {
        REG_CAL_A  = 3'd0,
        REG_CAL_B  = 3'd1,
        REG_B1     = 3'd2,
        REG_B2     = 3'd3,
        REG_MC     = 3'd4,
        REG_MD     = 3'd5,
        REG_OSS    = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_PRESS_DIV0 = 2'd1,
        ST_TEMP_DIV0  = 2'd2
    } status_t;

    typedef struct packed {
        logic [15:0] ut;
        logic [18:0] up;
    } item_t;

    typedef struct packed {
        logic [15:0] ac1;
        logic [15:0] ac2;
        logic [15:0] ac3;
        logic [15:0] ac4;
        logic [15:0] ac5;
        logic [15:0] ac6;
        logic [15:0] b1;
        logic [15:0] b2;
        logic [15:0] mc;
        logic [15:0] md;
        logic [1:0]  oss;
    } cal_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quot;
        logic [31:0] rem;
    } div_rsp_t;

    // Arithmetic right shift of a 32-bit two's-complement word
    function automatic logic [31:0] asr(input logic [31:0] v, input int s);
        return $unsigned($signed(v) >>> s);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

FILE: hdl/bpc_front.sv
// Front end of the compensation block: takes reading pairs and holds them
// in a short queue for the back end. Depends on bpc_pkg.
module bpc_front #(
    parameter int DEPTH = bpc_pkg::QueueDepth
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  bpc_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output bpc_pkg::item_t  head_item
);
    import bpc_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

    item_t           entry_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] cnt_reg;

    assign full       = (cnt_reg == CntW'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                entry_reg[wr_ptr_reg] <= push_item;
                wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CntW'(DEPTH))
        else $error("queue count above depth");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

endmodule

FILE: hdl/bpc_div.sv
// Unsigned 32-bit restoring divider, two quotient bits per cycle.
// Depends on bpc_pkg.
module bpc_div (
    input  logic                clk,
    input  logic                rst_n,
    input  bpc_pkg::div_req_t   req,
    output bpc_pkg::div_rsp_t   rsp
);
    import bpc_pkg::*;

    logic [31:0] q_reg;
    logic [31:0] rem_reg;
    logic [31:0] d_reg;
    logic [3:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] step1;
    logic [63:0] step2;

    function automatic logic [63:0] div_step(input logic [31:0] r, input logic [31:0] q,
                                             input logic [31:0] d);
        logic [32:0] r33;
        logic [32:0] diff;
        r33  = {r, q[31]};
        diff = r33 - {1'b0, d};
        if (!diff[32])
            return {diff[31:0], q[30:0], 1'b1};
        return {r33[31:0], q[30:0], 1'b0};
    endfunction

    assign step1 = div_step(rem_reg, q_reg, d_reg);
    assign step2 = div_step(step1[63:32], step1[31:0], d_reg);

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;
    assign rsp.rem  = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                q_reg    <= req.dividend;
                rem_reg  <= '0;
                d_reg    <= req.divisor;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= step2[63:32];
                q_reg   <= step2[31:0];
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 4'hF)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: hdl/bpc_back.sv
// Back end: sequencer with one shared 32x32 multiplier and the divider,
// evaluates temperature and pressure for one reading pair. Depends on
// bpc_pkg and bpc_div.
module bpc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  bpc_pkg::cal_t   cal,
    input  logic            head_valid,
    input  bpc_pkg::item_t  head_item,
    output logic            pop,
    output logic            done,
    output logic [15:0]     temp_deci_c,
    output logic [19:0]     press_pa,
    output logic [1:0]      status
);
    import bpc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_T1, S_T2, S_TGO, S_TWAIT, S_T3, S_T4,
        S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
        S_PGO, S_PWAIT, S_P11, S_P12, S_P13, S_P14, S_P15, S_EMIT
    } state_t;

    state_t      state_reg;
    logic [15:0] ut_reg;
    logic [18:0] up_reg;
    logic [31:0] x1_reg, x2_reg, x3_reg;
    logic [31:0] b5_reg, b6_reg, sq_reg, b3_reg, b4_reg, p_reg;
    logic        flag_reg;
    logic        done_reg;
    logic [15:0] temp_reg;
    logic [19:0] press_reg;
    logic [1:0]  status_reg;

    logic [31:0] mul_a, mul_b, mul_prod;
    logic [31:0] num_t, t_val, b3_pre, q_adj;
    div_req_t    div_req;
    div_rsp_t    div_rsp;

    bpc_div u_div (
        .clk (clk),
        .rst_n (rst_n),
        .req (div_req),
        .rsp (div_rsp)
    );

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_T1:
            begin
                mul_a = {16'b0, ut_reg} - {16'b0, cal.ac6};
                mul_b = {16'b0, cal.ac5};
            end
            S_P1:    begin mul_a = b6_reg;          mul_b = b6_reg; end
            S_P2:    begin mul_a = sx16(cal.b2);    mul_b = sq_reg; end
            S_P3:    begin mul_a = sx16(cal.ac2);   mul_b = b6_reg; end
            S_P5:    begin mul_a = sx16(cal.ac3);   mul_b = b6_reg; end
            S_P6:    begin mul_a = sx16(cal.b1);    mul_b = sq_reg; end
            S_P8:    begin mul_a = {16'b0, cal.ac4}; mul_b = x3_reg + HALF_SCALE; end
            S_P9:
            begin
                mul_a = {13'b0, up_reg} - b3_reg;
                mul_b = PRESS_SCALE >> cal.oss;
            end
            S_P11:   begin mul_a = asr(p_reg, 8);   mul_b = asr(p_reg, 8); end
            S_P12:   begin mul_a = x1_reg;          mul_b = COEF_SQ; end
            S_P13:   begin mul_a = COEF_LIN;        mul_b = p_reg; end
            default: begin mul_a = '0;              mul_b = '0; end
        endcase
    end

    assign mul_prod = 32'(mul_a * mul_b);

    // Temperature numerator MC*2048, exact in 32 bits
    assign num_t  = {{5{cal.mc[15]}}, cal.mc, 11'b0};
    assign t_val  = asr(b5_reg + 32'd8, 4);
    assign b3_pre = ((sx16(cal.ac1) << 2) + x3_reg) << cal.oss;
    // Floor correction for a negative quotient
    assign q_adj  = !flag_reg ? div_rsp.quot :
                    (div_rsp.rem != '0) ? ~div_rsp.quot : (32'd0 - div_rsp.quot);

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        if (state_reg == S_TGO)
        begin
            div_req.start    = 1'b1;
            div_req.dividend = num_t[31] ? (32'd0 - num_t) : num_t;
            div_req.divisor  = x3_reg[31] ? (32'd0 - x3_reg) : x3_reg;
        end
        else if (state_reg == S_PGO)
        begin
            div_req.start    = 1'b1;
            div_req.dividend = x1_reg[31] ? x1_reg : {x1_reg[30:0], 1'b0};
            div_req.divisor  = b4_reg;
        end
    end

    assign pop         = (state_reg == S_IDLE) && head_valid;
    assign done        = done_reg;
    assign temp_deci_c = temp_reg;
    assign press_pa    = press_reg;
    assign status      = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (head_valid)
                    begin
                        ut_reg    <= head_item.ut;
                        up_reg    <= head_item.up;
                        state_reg <= S_T1;
                    end
                end
                S_T1:
                begin
                    x1_reg    <= asr(mul_prod, 15);
                    state_reg <= S_T2;
                end
                S_T2:
                begin
                    // hold the divisor X1+MD in x3
                    x3_reg <= x1_reg + sx16(cal.md);
                    if ((x1_reg + sx16(cal.md)) == '0)
                    begin
                        temp_reg   <= '0;
                        press_reg  <= '0;
                        status_reg <= ST_TEMP_DIV0;
                        state_reg  <= S_EMIT;
                    end
                    else
                        state_reg <= S_TGO;
                end
                S_TGO:
                begin
                    flag_reg  <= num_t[31] ^ x3_reg[31];
                    state_reg <= S_TWAIT;
                end
                S_TWAIT:
                begin
                    if (div_rsp.done)
                    begin
                        x2_reg    <= q_adj;
                        state_reg <= S_T3;
                    end
                end
                S_T3:
                begin
                    b5_reg    <= x1_reg + x2_reg;
                    state_reg <= S_T4;
                end
                S_T4:
                begin
                    if ((&t_val[31:15]) || !(|t_val[31:15]))
                        temp_reg <= t_val[15:0];
                    else if (t_val[31])
                        temp_reg <= 16'h8000;
                    else
                        temp_reg <= 16'h7FFF;
                    b6_reg    <= b5_reg - TEMP_OFFSET;
                    state_reg <= S_P1;
                end
                S_P1:
                begin
                    sq_reg    <= asr(mul_prod, 12);
                    state_reg <= S_P2;
                end
                S_P2:
                begin
                    x1_reg    <= asr(mul_prod, 11);
                    state_reg <= S_P3;
                end
                S_P3:
                begin
                    x2_reg    <= asr(mul_prod, 11);
                    state_reg <= S_P4;
                end
                S_P4:
                begin
                    x3_reg    <= x1_reg + x2_reg;
                    state_reg <= S_P5;
                end
                S_P5:
                begin
                    b3_reg    <= asr(b3_pre + 32'd2, 2);
                    x1_reg    <= asr(mul_prod, 13);
                    state_reg <= S_P6;
                end
                S_P6:
                begin
                    x2_reg    <= asr(mul_prod, 16);
                    state_reg <= S_P7;
                end
                S_P7:
                begin
                    x3_reg    <= asr(x1_reg + x2_reg + 32'd2, 2);
                    state_reg <= S_P8;
                end
                S_P8:
                begin
                    b4_reg    <= mul_prod >> 15;
                    state_reg <= S_P9;
                end
                S_P9:
                begin
                    if (b4_reg == '0)
                    begin
                        press_reg  <= '0;
                        status_reg <= ST_PRESS_DIV0;
                        state_reg  <= S_EMIT;
                    end
                    else
                    begin
                        x1_reg    <= mul_prod;
                        state_reg <= S_PGO;
                    end
                end
                S_PGO:
                begin
                    flag_reg  <= x1_reg[31];
                    state_reg <= S_PWAIT;
                end
                S_PWAIT:
                begin
                    if (div_rsp.done)
                    begin
                        p_reg     <= flag_reg ? {div_rsp.quot[30:0], 1'b0} : div_rsp.quot;
                        state_reg <= S_P11;
                    end
                end
                S_P11:
                begin
                    x1_reg    <= mul_prod;
                    state_reg <= S_P12;
                end
                S_P12:
                begin
                    x1_reg    <= asr(mul_prod, 16);
                    state_reg <= S_P13;
                end
                S_P13:
                begin
                    x2_reg    <= asr(32'd0 - mul_prod, 16);
                    state_reg <= S_P14;
                end
                S_P14:
                begin
                    p_reg     <= p_reg + asr(x1_reg + x2_reg + COEF_OFS, 4);
                    state_reg <= S_P15;
                end
                S_P15:
                begin
                    if (p_reg[31])
                        press_reg <= '0;
                    else if (p_reg[31:20] != '0)
                        press_reg <= 20'hFFFFF;
                    else
                        press_reg <= p_reg[19:0];
                    status_reg <= ST_OK;
                    state_reg  <= S_EMIT;
                end
                S_EMIT:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_OK || status == ST_PRESS_DIV0 || status == ST_TEMP_DIV0))
        else $error("undefined status code");
    a_temp_div0: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_TEMP_DIV0) |-> (temp_deci_c == '0 && press_pa == '0))
        else $error("temperature divisor error with nonzero result");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

endmodule

FILE: hdl/barometer_temp_pressure_compensation_top.sv
// Top level of the barometric temperature/pressure compensation block:
// calibration registers, front queue and back-end sequencer.
// Depends on bpc_pkg, bpc_front, bpc_back (which holds bpc_div).
//
//  Channel   Signals                              Transaction
//  --------  -----------------------------------  ---------------------------
//  input     start, busy, raw_temp, raw_press     start && !busy
//  result    done, temp_deci_c, press_pa, status  done (one cycle, no stall)
//  config    cfg_valid, cfg_ready, cfg_index,     cfg_valid && cfg_ready
//            cfg_data
//
// Each reading pair makes up to two passes of the radix-4 divider in the
// back end, one for temperature and one for pressure, plus its steps on the
// shared multiplier.
// The front queue (QUEUE_DEPTH pairs) takes new transactions while the back
// end works; busy rises only when that queue is full.
// Reset is asynchronous, active low; it clears the calibration and control
// registers, not the data registers, and empties the queue. No clearing pass is needed.
// The result receiver cannot stall: each result is shown for one cycle.
module barometer_temp_pressure_compensation_top #(
    parameter int QUEUE_DEPTH = bpc_pkg::QueueDepth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] raw_temp,
    input  logic [18:0] raw_press,
    output logic        done,
    output logic [15:0] temp_deci_c,
    output logic [19:0] press_pa,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);
    import bpc_pkg::*;

    logic [47:0] cal_a_reg;
    logic [47:0] cal_b_reg;
    logic [15:0] b1_reg;
    logic [15:0] b2_reg;
    logic [15:0] mc_reg;
    logic [15:0] md_reg;
    logic [1:0]  oss_reg;

    cal_t  cal;
    item_t push_item;
    item_t head_item;
    logic  push;
    logic  full;
    logic  pop;
    logic  head_valid;

    // Registers are always writable; write them only while nothing is in flight
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_a_reg <= '0;
            cal_b_reg <= '0;
            b1_reg    <= '0;
            b2_reg    <= '0;
            mc_reg    <= '0;
            md_reg    <= '0;
            oss_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // drop writes to unknown indexes
            case (cfg_index)
                REG_CAL_A: cal_a_reg <= cfg_data;
                REG_CAL_B: cal_b_reg <= cfg_data;
                REG_B1:    b1_reg    <= cfg_data[15:0];
                REG_B2:    b2_reg    <= cfg_data[15:0];
                REG_MC:    mc_reg    <= cfg_data[15:0];
                REG_MD:    md_reg    <= cfg_data[15:0];
                REG_OSS:   oss_reg   <= cfg_data[1:0];
                default:   ;
            endcase
        end
    end

    // Unpack the calibration words: AC1/AC4 sit in the low bits
    assign cal.ac1 = cal_a_reg[15:0];
    assign cal.ac2 = cal_a_reg[31:16];
    assign cal.ac3 = cal_a_reg[47:32];
    assign cal.ac4 = cal_b_reg[15:0];
    assign cal.ac5 = cal_b_reg[31:16];
    assign cal.ac6 = cal_b_reg[47:32];
    assign cal.b1  = b1_reg;
    assign cal.b2  = b2_reg;
    assign cal.mc  = mc_reg;
    assign cal.md  = md_reg;
    assign cal.oss = oss_reg;

    // Accept a reading pair whenever the queue has room
    assign busy         = full;
    assign push         = start && !full;
    assign push_item.ut = raw_temp;
    assign push_item.up = raw_press;

    bpc_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    bpc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cal         (cal),
        .head_valid  (head_valid),
        .head_item   (head_item),
        .pop         (pop),
        .done        (done),
        .temp_deci_c (temp_deci_c),
        .press_pa    (press_pa),
        .status      (status)
    );

endmodule
